>>> sv/wrrqp_pkg.sv
package wrrqp_pkg;

	// Default number of credit slots and pointer range
	localparam int MaxQueuesDef = 4;

	// Fixed field widths
	localparam int QcntW      = 3;
	localparam int WeightW    = 8;
	localparam int CreditW    = 9;
	localparam int MaskW      = 4;
	localparam int OutQW      = 2;
	localparam int NumWeights = 4;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 8;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegQueueCount = 3'd0;
	localparam logic [CfgIdxW-1:0] RegWeightQ0   = 3'd1;
	localparam logic [CfgIdxW-1:0] RegWeightQ1   = 3'd2;
	localparam logic [CfgIdxW-1:0] RegWeightQ2   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegWeightQ3   = 3'd4;

	// Register reset values
	localparam logic [QcntW-1:0]   QcountRst  = 3'd3;
	localparam logic [WeightW-1:0] WeightQ0Rst = 8'd1;
	localparam logic [WeightW-1:0] WeightQ1Rst = 8'd1;
	localparam logic [WeightW-1:0] WeightQ2Rst = 8'd0;
	localparam logic [WeightW-1:0] WeightQ3Rst = 8'd0;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SKIP
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic eval;    // credit check or advance, capture mask
		logic skip;    // drop an empty queue and advance
		logic finish;  // load the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic skip_needed;
		logic out_free;
	} stat_t;

endpackage

>>> sv/wrrqp_ctrl.sv
module wrrqp_ctrl import wrrqp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat_i,
	output cmd_t  cmd_o
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_o    = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd_o.eval = 1'b1;
					state_d    = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (stat_i.skip_needed) begin
					cmd_o.skip = 1'b1;
				end else if (stat_i.out_free) begin
					cmd_o.finish = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/wrrqp_dp.sv
module wrrqp_dp import wrrqp_pkg::*; #(
	parameter int MAX_QUEUES = MaxQueuesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic [MaskW-1:0]    nonempty_mask,
	input  cmd_t                cmd_i,
	output stat_t               stat_o,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OutQW-1:0]    chosen_queue,
	output logic                found
);

	localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int NW = $clog2(MAX_QUEUES + 1);

	logic [QcntW-1:0]          qcount_q;
	logic [WeightW-1:0]        weight_q [NumWeights];
	logic [QW-1:0]             cur_q;
	logic signed [CreditW-1:0] credit_q [MAX_QUEUES];
	logic [MaskW-1:0]          mask_q;
	logic [NW-1:0]             cnt_q;
	logic                      out_valid_q;
	logic [OutQW-1:0]          chosen_q;
	logic                      found_q;

	logic [NW-1:0]             n_act;
	logic [WeightW-1:0]        wext [MAX_QUEUES];
	logic [MAX_QUEUES-1:0]     ne_vec;
	logic [QW-1:0]             nxt_q;
	logic signed [CreditW-1:0] load_val;
	logic signed [CreditW-1:0] cur_cred;
	logic                      adv_eval;
	logic                      skip_needed;

	// Small remainder by repeated compare and subtract; value never exceeds MAX_QUEUES
	function automatic logic [QW-1:0] mod_n(input logic [NW-1:0] v, input logic [NW-1:0] m);
		logic [NW-1:0] r;
		r = v;
		for (int k = 0; k < MAX_QUEUES; k++) begin
			if (r >= m) begin
				r = r - m;
			end
		end
		return QW'(r);
	endfunction

	always_comb begin
		if (qcount_q == '0) begin
			n_act = NW'(1);
		end else if (qcount_q > MAX_QUEUES) begin
			n_act = NW'(MAX_QUEUES);
		end else begin
			n_act = NW'(qcount_q);
		end
		// Queues without a weight register or mask bit read as weight 0, empty
		for (int k = 0; k < MAX_QUEUES; k++) begin
			wext[k]   = (k < NumWeights) ? weight_q[k[1:0]] : '0;
			ne_vec[k] = (k < MaskW) ? mask_q[k[1:0]] : 1'b0;
		end
		nxt_q       = mod_n(NW'(cur_q) + NW'(1), n_act);
		load_val    = $signed({1'b0, wext[nxt_q]}) - 9'sd1;
		cur_cred    = credit_q[cur_q];
		adv_eval    = (cur_cred <= 9'sd0);
		skip_needed = (cnt_q < n_act) && !ne_vec[cur_q];
	end

	assign stat_o.skip_needed = skip_needed;
	assign stat_o.out_free    = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q    <= QcountRst;
			weight_q[0] <= WeightQ0Rst;
			weight_q[1] <= WeightQ1Rst;
			weight_q[2] <= WeightQ2Rst;
			weight_q[3] <= WeightQ3Rst;
		end else if (cfg_wen) begin
			case (cfg_index)
				RegQueueCount: qcount_q    <= cfg_data[QcntW-1:0];
				RegWeightQ0:   weight_q[0] <= cfg_data[WeightW-1:0];
				RegWeightQ1:   weight_q[1] <= cfg_data[WeightW-1:0];
				RegWeightQ2:   weight_q[2] <= cfg_data[WeightW-1:0];
				RegWeightQ3:   weight_q[3] <= cfg_data[WeightW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			cnt_q <= '0;
			for (int k = 0; k < MAX_QUEUES; k++) begin
				credit_q[k] <= '0;
			end
		end else begin
			if (cmd_i.eval) begin
				cnt_q <= '0;
				if (adv_eval) begin
					cur_q <= nxt_q;
				end
			end else if (cmd_i.skip) begin
				cnt_q <= cnt_q + NW'(1);
				cur_q <= nxt_q;
			end
			for (int k = 0; k < MAX_QUEUES; k++) begin
				if (cmd_i.eval) begin
					if (adv_eval && (QW'(k) == nxt_q)) begin
						credit_q[k] <= load_val;
					end else if (!adv_eval && (QW'(k) == cur_q)) begin
						credit_q[k] <= cur_cred - 9'sd1;
					end
				end else if (cmd_i.skip) begin
					// zero the empty queue; the reload wins when both hit one slot
					if (QW'(k) == nxt_q) begin
						credit_q[k] <= load_val;
					end else if (QW'(k) == cur_q) begin
						credit_q[k] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.eval) begin
			mask_q <= nonempty_mask;
		end
		if (cmd_i.finish) begin
			chosen_q <= OutQW'(cur_q);
			found_q  <= ne_vec[cur_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_queue = chosen_q;
	assign found        = found_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.skip |-> (cnt_q < n_act))
		else $error("skip count beyond active queue count");
	a_finish_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.finish |-> !skip_needed)
		else $error("result loaded while a skip is pending");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.finish |=> out_valid_q)
		else $error("result register not valid after load");
	a_credit_floor: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q[cur_q] >= -9'sd1)
		else $error("credit of current queue below minus one");
`endif

endmodule

>>> sv/weighted_round_robin_queue_picker_core.sv
// Flow: a request is accepted in idle, empty queues are then skipped, and the result is loaded
// into the output register once that register is free; out_valid is registered.
// A new request is taken only once the previous one has loaded its result; 0 up to the active
// count of empty queues are skipped per request, one per cycle by the datapath skip loop.
// A waiting result is held in the output register; the block can still start the next request.
// Reset (arst_n low, asynchronous): pointer and credits clear, registers take their reset values.
module weighted_round_robin_queue_picker_core import wrrqp_pkg::*; #(
	parameter int MAX_QUEUES = MaxQueuesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_wen,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MaskW-1:0]    nonempty_mask,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OutQW-1:0]    chosen_queue,
	output logic                found
);

	// Commands from the sequencer and status back from the datapath
	cmd_t  cmd;
	stat_t stat;

	// Sequencer: take a request in idle, then loop over empty queues, then post the result
	wrrqp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat_i   (stat),
		.cmd_o    (cmd)
	);

	// Datapath: registers, pointer, per-queue credits, skip counter and result register
	wrrqp_dp #(
		.MAX_QUEUES (MAX_QUEUES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.nonempty_mask (nonempty_mask),
		.cmd_i         (cmd),
		.stat_o        (stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chosen_queue  (chosen_queue),
		.found         (found)
	);

endmodule

>>> test/tb_weighted_round_robin_queue_picker_core.sv
`timescale 1ns / 1ps

module tb_weighted_round_robin_queue_picker_core;
	import wrrqp_pkg::*;

	// Run shape
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 10;      // longest pick skips up to 4 empty queues
	localparam int IDLE_PCT      = 13;
	localparam int HOLD_CYCLES   = 80;
	localparam int NUM_PHASES    = 12;
	localparam int PHASE_ITEMS   = 100;
	localparam int QUIET_PHASE   = 3;       // neither side idles in this phase
	localparam int HOLD_PHASE    = 5;       // result side holds off for a long stretch
	localparam int PAUSE_PHASE   = 7;       // request side waits for all results mid-phase
	localparam int MAX_REPORTS   = 10;

	// Register indexes past the end of the list; writes to them must be dropped
	localparam logic [CfgIdxW-1:0] RegSpare5 = 3'd5;
	localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

	// One pick as it leaves the block
	typedef struct packed {
		logic [OutQW-1:0] queue;
		logic             found;
	} pick_t;

	typedef enum logic {
		ROW_CFG,
		ROW_REQ
	} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] data;
		logic [MaskW-1:0]    mask;
		logic                typed;   // use the typed pick instead of the predictor
		pick_t               want;
	} stim_row_t;

	localparam int NUM_ROWS = 31;

	// Directed opening: extremes, wrap, saturation, dropped writes, stale pointer
	stim_row_t script [NUM_ROWS] = '{
		// from reset the pointer sits on queue 0 with no credit: move to queue 1
		'{ROW_REQ, '0, '0, 4'b1111, 1'b1, '{2'd1, 1'b1}},
		// everything empty: sweep all three queues and rest on queue 2
		'{ROW_REQ, '0, '0, 4'b0000, 1'b1, '{2'd2, 1'b0}},
		'{ROW_CFG, RegQueueCount, 8'd1, '0, 1'b0, '0},
		// single queue: the pointer wraps straight back to 0
		'{ROW_REQ, '0, '0, 4'b0001, 1'b1, '{2'd0, 1'b1}},
		'{ROW_REQ, '0, '0, 4'b0000, 1'b1, '{2'd0, 1'b0}},
		// queue count of zero acts as one
		'{ROW_CFG, RegQueueCount, 8'd0, '0, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1110, 1'b1, '{2'd0, 1'b0}},
		// queue count above the maximum saturates; weights at both extremes
		'{ROW_CFG, RegQueueCount, 8'd7, '0, 1'b0, '0},
		'{ROW_CFG, RegWeightQ0, 8'd255, '0, 1'b0, '0},
		'{ROW_CFG, RegWeightQ1, 8'd0, '0, 1'b0, '0},
		'{ROW_CFG, RegWeightQ2, 8'd3, '0, 1'b0, '0},
		'{ROW_CFG, RegWeightQ3, 8'd255, '0, 1'b0, '0},
		'{ROW_CFG, RegSpare5, 8'hFF, '0, 1'b0, '0},
		'{ROW_CFG, RegSpare6, 8'hAA, '0, 1'b0, '0},
		'{ROW_CFG, RegSpare7, 8'h55, '0, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1111, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1111, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1111, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1000, 1'b0, '0},
		// lower the count while the pointer sits on queue 3
		'{ROW_CFG, RegQueueCount, 8'd2, '0, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b0100, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1100, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b0011, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1010, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b0101, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b0010, 1'b0, '0},
		'{ROW_CFG, RegQueueCount, 8'd4, '0, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1001, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1001, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b0001, 1'b0, '0},
		'{ROW_REQ, '0, '0, 4'b1111, 1'b0, '0}
	};

	// Block ports; every input starts at a known value
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [MaskW-1:0]    nonempty_mask = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [OutQW-1:0]    chosen_queue;
	logic                found;

	// Typed pick riding along with the request payload
	logic  req_typed = 1'b0;
	pick_t req_want = '0;

	// Picker state and registers as the predictor sees them
	logic [QcntW-1:0]          qcount_cfg = QcountRst;
	logic [WeightW-1:0]        weight_cfg [NumWeights] =
		'{WeightQ0Rst, WeightQ1Rst, WeightQ2Rst, WeightQ3Rst};
	logic [OutQW-1:0]          ptr = '0;
	logic signed [CreditW-1:0] credit_bal [MaxQueuesDef] = '{default: '0};

	pick_t pick_expect [$];
	int    mismatches = 0;
	bit    quiet = 1'b0;
	int    hold_asks = 0;

	weighted_round_robin_queue_picker_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.nonempty_mask (nonempty_mask),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chosen_queue  (chosen_queue),
		.found         (found)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block wedges
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("weighted_round_robin_queue_picker_core test failed");
		$finish;
	end

	// Move the pointer with wrap and load the new queue's credit as weight minus one
	function automatic void step_pointer(int n);
		ptr = OutQW'((int'(ptr) + 1) % n);
		credit_bal[ptr] = $signed({1'b0, weight_cfg[ptr]}) - 9'sd1;
	endfunction

	// Spend or roll credit, then skip empty queues at most once around
	function automatic pick_t pick_queue(logic [MaskW-1:0] mask);
		int    n;
		pick_t r;
		n = (qcount_cfg == 0) ? 1 :
			(qcount_cfg > MaxQueuesDef) ? MaxQueuesDef : int'(qcount_cfg);
		if (credit_bal[ptr] <= 0) begin
			step_pointer(n);
		end else begin
			credit_bal[ptr] = credit_bal[ptr] - 9'sd1;
		end
		for (int i = 0; i < n && !mask[ptr]; i++) begin
			credit_bal[ptr] = '0;
			step_pointer(n);
		end
		r.queue = ptr;
		r.found = mask[ptr];
		return r;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endfunction

	// Mostly random masks, with all-empty, one-hot and all-full ones mixed in
	function automatic logic [MaskW-1:0] random_mask();
		int roll = $urandom_range(0, 99);
		if (roll < 15) return '0;
		if (roll < 30) return MaskW'(1) << $urandom_range(0, MaskW - 1);
		if (roll < 35) return '1;
		return MaskW'($urandom_range(0, (1 << MaskW) - 1));
	endfunction

	function automatic logic [CfgDataW-1:0] random_weight();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2, 3, 4: return CfgDataW'($urandom_range(1, 3));
			default: return CfgDataW'($urandom_range(0, 255));
		endcase
	endfunction

	// Write one register; drop the enable on the next falling edge
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Offer one request, idling at random first, and hold it until accepted
	task automatic send_request(logic [MaskW-1:0] mask, logic typed, pick_t want);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		nonempty_mask <= mask;
		req_typed     <= typed;
		req_want      <= want;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering, wait for every pending pick, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pick_expect.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off when asked for
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_asks != hold_seen) begin
				hold_seen++;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Track register writes, predict each accepted request, check each result
	always @(posedge clk) begin
		pick_t got;
		pick_t want;
		pick_t predicted;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{chosen_queue, found};
				if (pick_expect.size() == 0) begin
					note_mismatch($sformatf("unexpected result queue=%0d found=%0b",
						got.queue, got.found));
				end else begin
					want = pick_expect.pop_front();
					if (got.queue !== want.queue || got.found !== want.found) begin
						note_mismatch($sformatf("expected queue=%0d found=%0b, got queue=%0d found=%0b",
							want.queue, want.found, got.queue, got.found));
					end
				end
			end
			if (in_valid && !in_stall) begin
				predicted = pick_queue(nonempty_mask);
				pick_expect.push_back(req_typed ? req_want : predicted);
			end
			if (cfg_wen) begin
				case (cfg_index)
					RegQueueCount: qcount_cfg = cfg_data[QcntW-1:0];
					RegWeightQ0, RegWeightQ1, RegWeightQ2, RegWeightQ3:
						weight_cfg[int'(cfg_index) - int'(RegWeightQ0)] = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Request side: reset, directed rows, then randomized phases
	initial begin
		logic [CfgIdxW-1:0] widx;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[r]) begin
			if (script[r].kind == ROW_CFG) begin
				drain();
				write_reg(script[r].idx, script[r].data);
			end else begin
				send_request(script[r].mask, script[r].typed, script[r].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// reprogram only with nothing in flight
			drain();
			if ($urandom_range(0, 9) == 0) begin
				write_reg(RegQueueCount, CfgDataW'($urandom_range(0, 7)));
			end else begin
				write_reg(RegQueueCount, CfgDataW'($urandom_range(1, MaxQueuesDef)));
			end
			for (int w = 0; w < NumWeights; w++) begin
				widx = CfgIdxW'(int'(RegWeightQ0) + w);
				write_reg(widx, random_weight());
			end
			quiet = (ph == QUIET_PHASE);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// hold off the result side and keep pushing until the block backs up
				if (ph == HOLD_PHASE && k == 10) hold_asks++;
				// pause requests until every pick is back
				if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) drain();
				send_request(random_mask(), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		drain();
		if (mismatches == 0 && pick_expect.size() == 0) begin
			$display("weighted_round_robin_queue_picker_core test passed");
		end else begin
			$display("weighted_round_robin_queue_picker_core test failed");
		end
		$finish;
	end

endmodule
